// ===== hw/rtl/fbt_pkg.sv =====
`default_nettype none

package fbt_pkg;

	localparam int CMD_W      = 2;
	localparam int KEY_W      = 64;
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 32;
	localparam int ATT_W      = 4;
	localparam int PROD_W     = TIME_W + ATT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int ENTRIES_DEF  = 128;
	localparam int KEY_BITS_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_TEMP  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RETRY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PERM  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_BASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_CAP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERM_COOL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ATT_CAP    = 3'd5;

	localparam logic [TIME_W-1:0] TEMP_BASE_RST  = 32'd10000;
	localparam logic [TIME_W-1:0] TEMP_CAP_RST   = 32'd120000;
	localparam logic [TIME_W-1:0] RETRY_BASE_RST = 32'd20000;
	localparam logic [TIME_W-1:0] RETRY_CAP_RST  = 32'd300000;
	localparam logic [TIME_W-1:0] PERM_COOL_RST  = 32'd1800000;
	localparam logic [ATT_W-1:0]  ATT_CAP_RST    = 4'd10;

endpackage

`default_nettype wire

// ===== hw/rtl/fbt_intf.sv =====
`default_nettype none

interface fbt_cfg_if import fbt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface fbt_req_if import fbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [KEY_W-1:0]  act_key;
	logic [KIND_W-1:0] failure_kind;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, cmd, act_key, failure_kind, now_ms, input ready);
	modport sink (input valid, cmd, act_key, failure_kind, now_ms, output ready);
endinterface

interface fbt_rsp_if import fbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [ATT_W-1:0]  attempt_count;
	logic [KIND_W-1:0] kind_stored;
	logic [TIME_W-1:0] last_attempt_ms;
	logic [TIME_W-1:0] cooldown_end_ms;
	logic              evicted;

	modport source (output valid, found, attempt_count, kind_stored, last_attempt_ms,
		cooldown_end_ms, evicted, input ready);
	modport sink (input valid, found, attempt_count, kind_stored, last_attempt_ms,
		cooldown_end_ms, evicted, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/failure_backoff_table.sv =====
// Failure backoff table: up to ENTRIES records keyed by the low KEY_BITS bits of act_key,
// held in one single-port-write, registered-read RAM. Each command with a nonzero key, other
// than the no-operation command, reads every slot once, one slot per cycle, to find the key,
// the first free slot and the oldest record. The MUL state then forms the cooldown product and
// the FIN state writes back and posts the result word; the next command is taken only once
// the block is back in idle, so commands do not overlap. A result word that is not taken holds
// the next write-back in FIN until it is. A zero key or the no-operation command skips the
// scan, goes straight to FIN and answers with an all-zero word. After reset the block clears
// every RAM slot before it accepts its first command; configuration writes are accepted at
// any time and must only be issued while the block is idle.
`default_nettype none

module failure_backoff_table import fbt_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fbt_cfg_if.sink    cfg,
	fbt_req_if.sink    req,
	fbt_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic                valid;
		logic [KEY_BITS-1:0] key;
		logic [ATT_W-1:0]    att;
		logic [KIND_W-1:0]   kind;
		logic [TIME_W-1:0]   last;
		logic [TIME_W-1:0]   cool;
	} slot_t;

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0] temp_base_q, temp_cap_q, retry_base_q, retry_cap_q, perm_cool_q;
	logic [ATT_W-1:0]  att_cap_q;

	slot_t            mem [ENTRIES];
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	slot_t            mem_wd;
	slot_t            rd_s1;

	logic [CNT_W-1:0] cnt_q;
	logic             rvld_s1;
	logic [IDX_W-1:0] ridx_s1;

	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KIND_W-1:0]   kind_q;
	logic [TIME_W-1:0]   now_q;
	logic                null_q;

	logic              hit_q, free_q;
	logic [IDX_W-1:0]  hit_idx_q, free_idx_q, old_idx_q;
	logic [ATT_W-1:0]  hit_att_q;
	logic [KIND_W-1:0] hit_kind_q;
	logic [TIME_W-1:0] hit_last_q, hit_cool_q, old_last_q;

	logic [ATT_W-1:0]  att_q;
	logic [PROD_W-1:0] prod_q;
	logic [TIME_W-1:0] cap_q;

	logic              rsp_valid_q, rsp_found_q, rsp_evicted_q;
	logic [ATT_W-1:0]  rsp_att_q;
	logic [KIND_W-1:0] rsp_kind_q;
	logic [TIME_W-1:0] rsp_last_q, rsp_cool_q;

	logic                req_fire, out_free, fin_fire, scan_issue;
	logic [KEY_BITS-1:0] key_in;
	logic [KIND_W-1:0]   kind_in;
	logic [ATT_W:0]      att_inc;
	logic [ATT_W-1:0]    att_sat, mult;
	logic [TIME_W-1:0]   base_sel, cap_sel, lim, cool;
	logic                is_record, is_query, is_clear, evict;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fin_fire  = (state_q == ST_FIN) && out_free;
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q < CNT_END);

	assign key_in  = req.act_key[KEY_BITS-1:0];
	assign kind_in = (req.failure_kind == KIND_RETRY || req.failure_kind == KIND_PERM) ?
		req.failure_kind : KIND_TEMP;

	assign is_record = !null_q && (cmd_q == CMD_RECORD);
	assign is_query  = !null_q && (cmd_q == CMD_QUERY);
	assign is_clear  = !null_q && (cmd_q == CMD_CLEAR);
	assign evict     = !hit_q && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_base_q  <= TEMP_BASE_RST;
			temp_cap_q   <= TEMP_CAP_RST;
			retry_base_q <= RETRY_BASE_RST;
			retry_cap_q  <= RETRY_CAP_RST;
			perm_cool_q  <= PERM_COOL_RST;
			att_cap_q    <= ATT_CAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TEMP_BASE:  temp_base_q  <= cfg.data;
				REG_TEMP_CAP:   temp_cap_q   <= cfg.data;
				REG_RETRY_BASE: retry_base_q <= cfg.data;
				REG_RETRY_CAP:  retry_cap_q  <= cfg.data;
				REG_PERM_COOL:  perm_cool_q  <= cfg.data;
				REG_ATT_CAP:    att_cap_q    <= cfg.data[ATT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem[cnt_q[IDX_W-1:0]];
	end

	always_comb begin
		att_inc  = hit_q ? ({1'b0, hit_att_q} + (ATT_W+1)'(1)) : (ATT_W+1)'(1);
		att_sat  = (att_inc > {1'b0, att_cap_q}) ? att_cap_q : att_inc[ATT_W-1:0];
		mult     = (att_sat == '0) ? ATT_W'(1) : att_sat;
		base_sel = (kind_q == KIND_RETRY) ? retry_base_q : temp_base_q;
		cap_sel  = (kind_q == KIND_RETRY) ? retry_cap_q : temp_cap_q;
		lim      = (prod_q > PROD_W'(cap_q)) ? cap_q : prod_q[TIME_W-1:0];
		cool     = now_q + ((kind_q == KIND_PERM) ? perm_cool_q : lim);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[IDX_W-1:0];
		mem_wd = '0;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
		end else if (fin_fire) begin
			if (is_record) begin
				mem_we = hit_q || free_q || (now_q >= old_last_q);
				mem_wa = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
				mem_wd = '{valid: 1'b1, key: key_q, att: att_q, kind: kind_q,
					last: now_q, cool: cool};
			end else if (is_clear) begin
				mem_we = hit_q;
				mem_wa = hit_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			null_q  <= 1'b0;
		end else begin
			rvld_s1 <= scan_issue;
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q[IDX_W-1:0] == IDX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						null_q  <= (key_in == '0) || (req.cmd == CMD_NONE);
						state_q <= ((key_in == '0) || (req.cmd == CMD_NONE)) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (rvld_s1) begin
						if (rd_s1.valid && rd_s1.key == key_q && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (!rd_s1.valid && !free_q) begin
							free_q <= 1'b1;
						end
					end else if (!scan_issue) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q  <= req.cmd;
			key_q  <= key_in;
			kind_q <= kind_in;
			now_q  <= req.now_ms;
		end
		if (scan_issue) begin
			ridx_s1 <= cnt_q[IDX_W-1:0];
		end
		if (state_q == ST_SCAN && rvld_s1) begin
			if (rd_s1.valid && rd_s1.key == key_q && !hit_q) begin
				hit_idx_q  <= ridx_s1;
				hit_att_q  <= rd_s1.att;
				hit_kind_q <= rd_s1.kind;
				hit_last_q <= rd_s1.last;
				hit_cool_q <= rd_s1.cool;
			end
			if (!rd_s1.valid && !free_q) begin
				free_idx_q <= ridx_s1;
			end
			if (ridx_s1 == '0 || rd_s1.last < old_last_q) begin
				old_idx_q  <= ridx_s1;
				old_last_q <= rd_s1.last;
			end
		end
		if (state_q == ST_MUL) begin
			att_q  <= att_sat;
			prod_q <= PROD_W'(base_sel) * PROD_W'(mult);
			cap_q  <= cap_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			rsp_found_q   <= !null_q && hit_q;
			rsp_evicted_q <= is_record && evict;
			rsp_att_q     <= '0;
			rsp_kind_q    <= '0;
			rsp_last_q    <= '0;
			rsp_cool_q    <= '0;
			if (is_record) begin
				rsp_att_q  <= att_q;
				rsp_kind_q <= kind_q;
				rsp_last_q <= now_q;
				rsp_cool_q <= cool;
			end else if (is_query && hit_q) begin
				rsp_att_q  <= hit_att_q;
				rsp_kind_q <= hit_kind_q;
				rsp_last_q <= hit_last_q;
				rsp_cool_q <= hit_cool_q;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.found           = rsp_found_q;
	assign rsp.attempt_count   = rsp_att_q;
	assign rsp.kind_stored     = rsp_kind_q;
	assign rsp.last_attempt_ms = rsp_last_q;
	assign rsp.cooldown_end_ms = rsp_cool_q;
	assign rsp.evicted         = rsp_evicted_q;

endmodule

`default_nettype wire
